// File: src/cps_pkg.sv
// Shared transaction types and field widths for the closest pair search block.
package cps_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 33;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [DIST_W-1:0]  dist_squared;
        logic               too_few;
        logic               overflowed;
    } t_result;

endpackage

// File: src/closest_pair_search.sv
// Brute-force closest pair of 2-D points over a point memory.
//
// Input transactions: a point (x, y, last_point) is taken at a rising edge
// with start high and busy low. Points load one per cycle while busy is
// low, into a MAX_POINTS-entry memory in load order; points past capacity
// are dropped and remembered as overflow.
// The point with last_point set ends the set. With fewer than two points
// stored, a too_few result comes out in the next cycle. Otherwise busy goes
// high and a sequencer walks every pair i < j, reading both points of one
// pair per cycle from the two read ports of the memory. A three-stage
// pipeline (memory read, abs difference and squaring, sum and compare)
// follows the sequencer; once the pipeline has drained, the result strobe
// o_valid is raised and busy drops in the cycle of the strobe.
// A result is on o_data for exactly one cycle under o_valid; the receiver
// cannot stall it. On ties the first pair in scan order is kept.
// Reset clears the point count, overflow flag, sequencer and strobe; the
// memory contents are not cleared, and only entries of the current set
// are ever used.
module closest_pair_search #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cps_pkg::t_point   i_data,
    output logic              o_valid,
    output cps_pkg::t_result  o_data
);

    localparam int CW   = (COORD_BITS < cps_pkg::COORD_W) ? COORD_BITS : cps_pkg::COORD_W;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SQW  = 2 * CW;
    localparam int DW   = SQW + 1;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    // Point memory: {x, y} per entry, two read ports for the pair.
    logic [2*CW-1:0] r_mem [MAX_POINTS];

    t_state          r_state;
    logic [CNTW-1:0] r_cnt;
    logic            r_ovf;
    logic [AW-1:0]   r_i, r_j;

    // Stage A: memory read data and pair tags
    logic            r_va;
    logic [2*CW-1:0] r_rda, r_rdb;
    logic [AW-1:0]   r_ta, r_tb;
    // Stage B: squared differences
    logic            r_vb;
    logic [SQW-1:0]  r_sx, r_sy;
    logic [AW-1:0]   r_ua, r_ub;
    logic [2*CW-1:0] r_pa, r_pb;
    // Running best
    logic [DW-1:0]   r_best;
    logic [AW-1:0]   r_bi, r_bj;
    logic [2*CW-1:0] r_bpa, r_bpb;

    logic            r_valid;
    cps_pkg::t_result r_out;

    logic            accept;
    logic            store_ok;
    logic [CNTW-1:0] n_cnt;
    logic            n_ovf;
    logic            issue;
    logic            last_j, last_i;
    logic [CW-1:0]   ax, ay, bx, by, dx, dy;
    logic [DW-1:0]   dsum;

    assign busy    = (r_state != S_LOAD);
    assign accept  = start && !busy;
    assign store_ok = (r_cnt < CNTW'(MAX_POINTS));
    assign n_cnt   = store_ok ? r_cnt + CNTW'(1) : r_cnt;
    assign n_ovf   = r_ovf || !store_ok;
    assign issue   = (r_state == S_SCAN);
    assign last_j  = (CNTW'(r_j) == r_cnt - CNTW'(1));
    assign last_i  = (CNTW'(r_i) == r_cnt - CNTW'(2));

    // Memory: write on load, both read ports run every cycle.
    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            r_mem[r_cnt[AW-1:0]] <= {CW'(i_data.x_coord), CW'(i_data.y_coord)};
        end
        r_rda <= r_mem[r_i];
        r_rdb <= r_mem[r_j];
        r_ta  <= r_i;
        r_tb  <= r_j;
    end

    // Stage B: abs difference and square
    always_comb begin
        ax = r_rda[2*CW-1:CW];
        ay = r_rda[CW-1:0];
        bx = r_rdb[2*CW-1:CW];
        by = r_rdb[CW-1:0];
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
    end

    always_ff @(posedge i_clk) begin
        r_sx <= SQW'(dx) * SQW'(dx);
        r_sy <= SQW'(dy) * SQW'(dy);
        r_ua <= r_ta;
        r_ub <= r_tb;
        r_pa <= r_rda;
        r_pb <= r_rdb;
    end

    assign dsum = DW'(r_sx) + DW'(r_sy);

    // Stage C: keep strictly smaller distance (first pair wins ties)
    always_ff @(posedge i_clk) begin
        if (accept && i_data.last_point) begin
            r_best <= '1;
        end else if (r_vb && (dsum < r_best)) begin
            r_best <= dsum;
            r_bi   <= r_ua;
            r_bj   <= r_ub;
            r_bpa  <= r_pa;
            r_bpb  <= r_pb;
        end
    end

    // Control: load, pair sequencer, drain, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_va    <= issue;
            r_vb    <= r_va;
            r_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (!i_data.last_point) begin
                            r_cnt <= n_cnt;
                            r_ovf <= n_ovf;
                        end else if (n_cnt < CNTW'(2)) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_valid <= 1'b1;
                            r_out   <= '{too_few: 1'b1, default: '0};
                        end else begin
                            r_cnt   <= n_cnt;
                            r_ovf   <= n_ovf;
                            r_i     <= '0;
                            r_j     <= AW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (last_j) begin
                        if (last_i) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + AW'(1);
                            r_j <= r_i + AW'(2);
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_va && !r_vb) begin
                        r_valid            <= 1'b1;
                        r_out.first_index  <= cps_pkg::INDEX_W'(r_bi);
                        r_out.second_index <= cps_pkg::INDEX_W'(r_bj);
                        r_out.first_x      <= cps_pkg::COORD_W'(r_bpa[2*CW-1:CW]);
                        r_out.first_y      <= cps_pkg::COORD_W'(r_bpa[CW-1:0]);
                        r_out.second_x     <= cps_pkg::COORD_W'(r_bpb[2*CW-1:CW]);
                        r_out.second_y     <= cps_pkg::COORD_W'(r_bpb[CW-1:0]);
                        r_out.dist_squared <= cps_pkg::DIST_W'(r_best);
                        r_out.too_few      <= 1'b0;
                        r_out.overflowed   <= r_ovf;
                        r_cnt              <= '0;
                        r_ovf              <= 1'b0;
                        r_state            <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    // A result only appears once the sequencer has released the block.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Pairs in flight are always ordered i < j.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> (r_ta < r_tb))
        else $error("pair tags out of order");

    // The scan never addresses beyond the stored points.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNTW'(r_j) < r_cnt))
        else $error("scan index past point count");

endmodule

// File: tb/closest_pair_search_test.sv
// Self-checking testbench for the closest pair search block: directed and random point sets against a predictor.
`timescale 1ns / 100ps

module closest_pair_search_test;

    localparam int CAPACITY  = 256;
    localparam int DRAIN_CYC = 24;     // settle time after the last result

    // Kinds of coordinate spread used to build a set.
    typedef enum int {
        SPREAD_FULL,    // anywhere in the full 16-bit coordinate range
        SPREAD_LOW,     // crowded near zero: duplicates and ties
        SPREAD_HIGH     // crowded near the top corner
    } t_spread;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    cps_pkg::t_point  i_data  = '0;
    logic             o_valid;
    cps_pkg::t_result o_data;

    closest_pair_search i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    cps_pkg::t_point  point_queue[$];     // points waiting for the driver
    cps_pkg::t_result pair_expect_q[$];   // predicted results, oldest first

    int      error_count    = 0;
    int      accepted_count = 0;
    int      set_count      = 0;
    int      result_count   = 0;
    int      too_few_count  = 0;
    int      overflow_count = 0;
    longint  cycle_count    = 0;
    longint  cycle_limit    = 0;
    longint  scan_budget    = 0;   // cycles the block spends searching, all sets
    int      item_total     = 0;

    // ------------------------------------------------------------------
    // Predictor: point store, count and overflow flag of the block
    // ------------------------------------------------------------------
    logic [cps_pkg::COORD_W-1:0] pt_x[CAPACITY];
    logic [cps_pkg::COORD_W-1:0] pt_y[CAPACITY];
    int                          stored_count = 0;
    bit                          dropped_flag = 1'b0;

    function automatic bit [63:0] pair_dist(int a, int b);
        bit [63:0] dx, dy;
        dx = (pt_x[a] > pt_x[b]) ? 64'(pt_x[a] - pt_x[b]) : 64'(pt_x[b] - pt_x[a]);
        dy = (pt_y[a] > pt_y[b]) ? 64'(pt_y[a] - pt_y[b]) : 64'(pt_y[b] - pt_y[a]);
        // 16-bit coordinates: the sum never gets near 64 bits, no saturation
        return dx * dx + dy * dy;
    endfunction

    // Takes one accepted point; returns 1 with the result when it closes a set.
    function automatic bit load_point(cps_pkg::t_point p, output cps_pkg::t_result r);
        int        bi, bj;
        bit [63:0] best, d;
        r = '0;
        if (stored_count < CAPACITY) begin
            pt_x[stored_count] = p.x_coord;
            pt_y[stored_count] = p.y_coord;
            stored_count++;
        end else begin
            dropped_flag = 1'b1;
        end
        if (!p.last_point) begin
            return 1'b0;
        end
        if (stored_count < 2) begin
            r.too_few = 1'b1;
        end else begin
            bi   = 0;
            bj   = 1;
            best = pair_dist(0, 1);
            for (int i = 0; i < stored_count; i++) begin
                for (int j = i + 1; j < stored_count; j++) begin
                    d = pair_dist(i, j);
                    // strict compare: on a tie the earlier pair stays
                    if (d < best) begin
                        best = d;
                        bi   = i;
                        bj   = j;
                    end
                end
            end
            r.first_index  = cps_pkg::INDEX_W'(bi);
            r.second_index = cps_pkg::INDEX_W'(bj);
            r.first_x      = pt_x[bi];
            r.first_y      = pt_y[bi];
            r.second_x     = pt_x[bj];
            r.second_y     = pt_y[bj];
            r.dist_squared = best[cps_pkg::DIST_W-1:0];
            r.overflowed   = dropped_flag;
        end
        stored_count = 0;
        dropped_flag = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_point(input logic [15:0] x, input logic [15:0] y, input logic last);
        cps_pkg::t_point p;
        p.x_coord    = x;
        p.y_coord    = y;
        p.last_point = last;
        point_queue = {point_queue, p};
        item_total++;
    endtask

    // Book-keeping for the run limit: pair scan plus pipeline per set.
    task automatic note_set(input int n);
        longint s;
        s = (n > CAPACITY) ? CAPACITY : n;
        scan_budget += s * (s - 1) / 2 + 8;
    endtask

    function automatic logic [15:0] pick_coord(t_spread sp);
        case (sp)
            SPREAD_LOW:  return 16'($urandom_range(0, 7));
            SPREAD_HIGH: return 16'hFFFF - 16'($urandom_range(0, 7));
            default:     return 16'($urandom);
        endcase
    endfunction

    task automatic add_random_set(input int n);
        t_spread sp;
        int      roll;
        roll = $urandom_range(0, 99);
        sp   = (roll < 60) ? SPREAD_FULL : (roll < 85) ? SPREAD_LOW : SPREAD_HIGH;
        for (int k = 0; k < n; k++) begin
            add_point(pick_coord(sp), pick_coord(sp), k == n - 1);
        end
        note_set(n);
    endtask

    // Full-capacity set with a duplicate planted at index b of the point at a;
    // with top_pair the winning pair lands at the top of the store. n > 256 drops the tail.
    task automatic add_big_set(input int n, input bit top_pair);
        int          a, b;
        logic [15:0] ax, ay, x, y;
        b = top_pair ? CAPACITY - 1 : $urandom_range(1, CAPACITY - 1);
        a = top_pair ? $urandom_range(CAPACITY / 2, CAPACITY - 2) : $urandom_range(0, b - 1);
        ax = '0;
        ay = '0;
        for (int k = 0; k < n; k++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            if (k == a) begin
                ax = x;
                ay = y;
            end
            if (k == b) begin
                x = ax;
                y = ay;
            end
            add_point(x, y, k == n - 1);
        end
        note_set(n);
    endtask

    // ------------------------------------------------------------------
    // Driver: one point offered per cycle outside idle gaps, held until start && !busy
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit               handed;
        bit               have_result;
        int               idle_pct;
        cps_pkg::t_result r;
        if (i_rst_n) begin
            handed = start && !busy;
            if (handed) begin
                have_result = load_point(i_data, r);
                if (have_result) begin
                    pair_expect_q = {pair_expect_q, r};
                end
                accepted_count++;
            end
            // Idle phases by transaction count: none, 45%, none, 30%.
            case ((accepted_count / 100) % 4)
                1:       idle_pct = 45;
                3:       idle_pct = 30;
                default: idle_pct = 0;
            endcase
            if (start && !handed) begin
                // blocked by busy: keep the transaction on the bus
            end else if (point_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start  <= 1'b1;
                i_data <= point_queue.pop_front();
            end else begin
                start  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result is checked against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cps_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pair_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected, got %h", $time, o_data);
            end else begin
                want = pair_expect_q.pop_front();
                check_field("first_index",  want.first_index,  o_data.first_index);
                check_field("second_index", want.second_index, o_data.second_index);
                check_field("first_x",      want.first_x,      o_data.first_x);
                check_field("first_y",      want.first_y,      o_data.first_y);
                check_field("second_x",     want.second_x,     o_data.second_x);
                check_field("second_y",     want.second_y,     o_data.second_y);
                check_field("dist_squared", want.dist_squared, o_data.dist_squared);
                check_field("too_few",      want.too_few,      o_data.too_few);
                check_field("overflowed",   want.overflowed,   o_data.overflowed);
                result_count++;
                if (want.too_few)    too_few_count++;
                if (want.overflowed) overflow_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int big_done;
        int roll;
        big_done = 0;

        // Directed sets
        add_point(16'hFFFF, 16'hFFFF, 1'b1);              // lone point: too few
        note_set(1);
        add_point(16'h0000, 16'h0000, 1'b0);              // opposite corners: max distance
        add_point(16'hFFFF, 16'hFFFF, 1'b1);
        note_set(2);
        add_point(16'h1234, 16'hABCD, 1'b0);              // duplicates: zero distance
        add_point(16'h1234, 16'hABCD, 1'b1);
        note_set(2);
        add_point(16'd0,  16'd0, 1'b0);                   // equal spacing: first pair wins
        add_point(16'd10, 16'd0, 1'b0);
        add_point(16'd20, 16'd0, 1'b1);
        note_set(3);
        add_point(16'd0,    16'd0,    1'b0);              // a later pair is strictly closer
        add_point(16'd1000, 16'd1000, 1'b0);
        add_point(16'd5000, 16'd5000, 1'b0);
        add_point(16'd5001, 16'd5000, 1'b1);
        note_set(4);
        add_point(16'hAAAA, 16'h5555, 1'b0);              // alternating bit patterns
        add_point(16'h5555, 16'hAAAA, 1'b1);
        note_set(2);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b1);
        note_set(2);
        add_point(16'h0000, 16'h0000, 1'b1);              // lone point at origin
        note_set(1);

        // Random sets; three full-store sets spread through the run,
        // the last two with dropped points (the final one drops its last point).
        while (item_total < 1350) begin
            if (big_done < 3 && item_total >= 300 * (big_done + 1)) begin
                case (big_done)
                    0:       add_big_set(CAPACITY, 1'b1);
                    1:       add_big_set(CAPACITY + 6, 1'b0);
                    default: add_big_set(CAPACITY + 1, 1'b0);
                endcase
                big_done++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    add_random_set(1);
                end else if (roll < 90) begin
                    add_random_set($urandom_range(2, 12));
                end else begin
                    add_random_set($urandom_range(13, 40));
                end
            end
            set_count++;
        end
        set_count += 8;
        cycle_limit = 4 * (scan_budget + 4 * item_total) + 20000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (point_queue.size() != 0 || start) @(posedge i_clk);
        while (pair_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("ran %0d points in %0d sets over %0d cycles", accepted_count, set_count,
                 cycle_count);
        $display("checked %0d results: %0d with too few points, %0d with dropped points",
                 result_count, too_few_count, overflow_count);
        if (error_count == 0) begin
            $display("closest_pair_search: match");
        end else begin
            $display("closest_pair_search: mismatch");
        end
        $finish;
    end

    // Watchdog: the limit is set at time zero from the generated stimulus.
    initial begin
        #1;
        while (cycle_count < cycle_limit) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                 cycle_count, pair_expect_q.size());
        $display("closest_pair_search: mismatch");
        $finish;
    end

endmodule
